/* src/flc_pkg.sv */
package flc_pkg;

  localparam int unsigned MAX_HEIGHT = 128;
  localparam int unsigned ROW_LIMIT  = 64;
  localparam int unsigned TEX_BITS   = 6;

  localparam logic [7:0]  SH_RESET  = 8'(MAX_HEIGHT);
  localparam logic [23:0] DIST_MAX  = 24'hFF_FFFF;
  localparam logic [31:0] WGT_MAX   = 32'hFFFF_FFFF;

  // divider iteration counts: row distance has a 24-bit quotient, weight 32 bits
  localparam logic [5:0] DIST_STEPS = 6'd24;
  localparam logic [5:0] WGT_STEPS  = 6'd32;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT = 2'd0;
  localparam cfg_idx_t CFG_PLAYER_X      = 2'd1;
  localparam cfg_idx_t CFG_PLAYER_Y      = 2'd2;

  typedef struct packed {
    logic        start;
    logic [5:0]  steps;
    logic [31:0] num;
    logic [23:0] rem0;
    logic [23:0] den;
  } flc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } flc_div_rsp_t;

  // low 16 bits of the interpolated position, then keep the texel index bits
  function automatic logic [TEX_BITS-1:0] tex_coord(input logic [15:0] player_lo,
                                                    input logic [15:0] prod_hi);
    logic [15:0] pos_lo;
    pos_lo = player_lo + prod_hi;
    return pos_lo[15 -: TEX_BITS];
  endfunction

endpackage

/* src/flc_in_if.sv */
interface flc_in_if;
  logic              valid;
  logic              ready;
  logic [8:0]        column;
  logic              hit_side;
  logic signed [1:0] ray_x_sign;
  logic signed [1:0] ray_y_sign;
  logic [5:0]        cell_x;
  logic [5:0]        cell_y;
  logic [15:0]       wall_frac;
  logic [23:0]       wall_distance;
  logic signed [8:0] draw_end;

  modport source (output valid, column, hit_side, ray_x_sign, ray_y_sign, cell_x, cell_y,
                  wall_frac, wall_distance, draw_end, input ready);
  modport sink (input valid, column, hit_side, ray_x_sign, ray_y_sign, cell_x, cell_y,
                wall_frac, wall_distance, draw_end, output ready);
endinterface

/* src/flc_out_if.sv */
interface flc_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] out_column;
  logic [6:0] floor_row;
  logic [7:0] ceiling_row;
  logic [5:0] tex_x;
  logic [5:0] tex_y;
  logic       last;

  modport source (output valid, out_column, floor_row, ceiling_row, tex_x, tex_y, last,
                  input ready);
  modport sink (input valid, out_column, floor_row, ceiling_row, tex_x, tex_y, last,
                output ready);
endinterface

/* src/flc_cfg_if.sv */
interface flc_cfg_if import flc_pkg::*;;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [21:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/floor_ceiling_texture_cast_unit.sv */
// Floor and ceiling texture caster, one screen column per input transaction.
// in_ch takes a column's ray-hit record; out_ch gives one transaction per floor
// row from max(draw_end, h-64) to h-1, with the mirrored ceiling row and the
// wrapped texture coordinates, last set on row h-1. A negative draw_end, or one
// at or past h, yields no output. cfg_ch writes screen_height, player_x and
// player_y (index 0, 1, 2); it is always ready and is meant for idle periods.
// Each row finds the row distance (24 quotient bits) and the weight (32 bits)
// on one radix-2 divider (one quotient bit per cycle), skipping a division whose
// result saturates, then the two products on one shared multiplier.
// in_ch.ready is high only between columns.
// Results go out through one output register; the next row is computed while
// a result waits, and the sequencer holds when that register is still full.
// Reset (rst_n low, synchronous) sets screen_height to 128, player position to
// zero, and empties the sequencer and output register.
module floor_ceiling_texture_cast_unit import flc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  flc_in_if.sink    in_ch,
  flc_out_if.source out_ch,
  flc_cfg_if.sink   cfg_ch
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ROW  = 8'b0000_0010,
    S_DIST = 8'b0000_0100,
    S_WSET = 8'b0000_1000,
    S_WGT  = 8'b0001_0000,
    S_MULX = 8'b0010_0000,
    S_MULY = 8'b0100_0000,
    S_PUSH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  sh_r;
  logic [21:0] px_r;
  logic [21:0] py_r;

  logic [8:0]  col_r, col_nxt;
  logic [22:0] wx_r, wx_nxt;
  logic [22:0] wy_r, wy_nxt;
  logic [23:0] wd_r, wd_nxt;
  logic [6:0]  y_r, y_nxt;
  logic [23:0] dist_r, dist_nxt;
  logic [31:0] w_r, w_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic [5:0]  tex_x_r, tex_x_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [8:0]  out_col_r, out_col_nxt;
  logic [6:0]  out_floor_r, out_floor_nxt;
  logic [7:0]  out_ceil_r, out_ceil_nxt;
  logic [5:0]  out_tx_r, out_tx_nxt;
  logic [5:0]  out_ty_r, out_ty_nxt;
  logic        out_last_r, out_last_nxt;

  logic [7:0]        h;
  logic signed [9:0] h_lim;
  logic signed [9:0] de_ext;
  logic signed [9:0] row_start;
  logic [6:0]        cx7, cy7;
  logic [22:0]       wx_in, wy_in;
  logic [8:0]        div9;
  logic              div_pos;
  logic              row_last;
  logic [23:0]       dx, dy;
  logic [31:0]       mul_b;
  logic [31:0]       prod_lo;

  flc_div_req_t div_req;
  flc_div_rsp_t div_rsp;

  flc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r <= SH_RESET;
      px_r <= '0;
      py_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SCREEN_HEIGHT: sh_r <= cfg_ch.data[7:0];
        CFG_PLAYER_X:      px_r <= cfg_ch.data;
        CFG_PLAYER_Y:      py_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign h = (sh_r > SH_RESET) ? SH_RESET : sh_r;

  // first row: no more than the bottom ROW_LIMIT rows
  assign h_lim     = $signed({2'b00, h}) - 10'(ROW_LIMIT);
  assign de_ext    = {in_ch.draw_end[8], in_ch.draw_end};
  assign row_start = (de_ext > h_lim) ? de_ext : h_lim;

  // wall point at the foot of the wall, Q7.16
  assign cx7 = {1'b0, in_ch.cell_x};
  assign cy7 = {1'b0, in_ch.cell_y};

  always_comb begin
    if (!in_ch.hit_side && in_ch.ray_x_sign == 2'sb01) begin
      wx_in = {cx7, 16'h0000};
      wy_in = {cy7, in_ch.wall_frac};
    end else if (!in_ch.hit_side && in_ch.ray_x_sign[1]) begin
      wx_in = {cx7 + 7'd1, 16'h0000};
      wy_in = {cy7, in_ch.wall_frac};
    end else if (in_ch.hit_side && in_ch.ray_y_sign == 2'sb01) begin
      wx_in = {cx7, in_ch.wall_frac};
      wy_in = {cy7, 16'h0000};
    end else begin
      wx_in = {cx7, in_ch.wall_frac};
      wy_in = {cy7 + 7'd1, 16'h0000};
    end
  end

  // row divisor 2y - h and last-row flag
  assign div9     = {1'b0, y_r, 1'b0} - {1'b0, h};
  assign div_pos  = !div9[8] && (div9 != '0);
  assign row_last = ({1'b0, y_r} + 8'd1) == h;

  // shared multiplier: only the low 32 product bits reach the texture index
  assign dx      = {1'b0, wx_r} - {2'b00, px_r};
  assign dy      = {1'b0, wy_r} - {2'b00, py_r};
  assign mul_b   = (state_r == S_MULX) ? {{8{dx[23]}}, dx} : {{8{dy[23]}}, dy};
  assign prod_lo = w_r * mul_b;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    wd_nxt        = wd_r;
    y_nxt         = y_r;
    dist_nxt      = dist_r;
    w_nxt         = w_r;
    prod_nxt      = prod_r;
    tex_x_nxt     = tex_x_r;
    out_valid_nxt = out_valid_r;
    out_col_nxt   = out_col_r;
    out_floor_nxt = out_floor_r;
    out_ceil_nxt  = out_ceil_r;
    out_tx_nxt    = out_tx_r;
    out_ty_nxt    = out_ty_r;
    out_last_nxt  = out_last_r;
    div_req       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          col_nxt = in_ch.column;
          wx_nxt  = wx_in;
          wy_nxt  = wy_in;
          wd_nxt  = (in_ch.wall_distance == '0) ? 24'd1 : in_ch.wall_distance;
          y_nxt   = row_start[6:0];
          // drop columns with no floor rows
          if (!in_ch.draw_end[8] && (row_start < $signed({2'b00, h}))) begin
            state_nxt = S_ROW;
          end
        end
      end
      S_ROW: begin
        if (div_pos) begin
          div_req.start = 1'b1;
          div_req.steps = DIST_STEPS;
          div_req.num   = {h, 24'h00_0000};
          div_req.rem0  = '0;
          div_req.den   = {16'h0000, div9[7:0]};
          state_nxt     = S_DIST;
        end else begin
          dist_nxt  = DIST_MAX;
          state_nxt = S_WSET;
        end
      end
      S_DIST: begin
        if (div_rsp.done) begin
          dist_nxt  = div_rsp.quo[23:0];
          state_nxt = S_WSET;
        end
      end
      S_WSET: begin
        // quotient overflows 32 bits when the top dividend byte already reaches or exceeds wd
        if ({16'h0000, dist_r[23:16]} >= wd_r) begin
          w_nxt     = WGT_MAX;
          state_nxt = S_MULX;
        end else begin
          div_req.start = 1'b1;
          div_req.steps = WGT_STEPS;
          div_req.num   = {dist_r[15:0], 16'h0000};
          div_req.rem0  = {16'h0000, dist_r[23:16]};
          div_req.den   = wd_r;
          state_nxt     = S_WGT;
        end
      end
      S_WGT: begin
        if (div_rsp.done) begin
          w_nxt     = div_rsp.quo;
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        prod_nxt  = prod_lo[31:16];
        state_nxt = S_MULY;
      end
      S_MULY: begin
        tex_x_nxt = tex_coord(px_r[15:0], prod_r);
        prod_nxt  = prod_lo[31:16];
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r;
          out_floor_nxt = y_r;
          out_ceil_nxt  = h - {1'b0, y_r};
          out_tx_nxt    = tex_x_r;
          out_ty_nxt    = tex_coord(py_r[15:0], prod_r);
          out_last_nxt  = row_last;
          if (row_last) begin
            state_nxt = S_IDLE;
          end else begin
            y_nxt     = y_r + 7'd1;
            state_nxt = S_ROW;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    wx_r        <= wx_nxt;
    wy_r        <= wy_nxt;
    wd_r        <= wd_nxt;
    y_r         <= y_nxt;
    dist_r      <= dist_nxt;
    w_r         <= w_nxt;
    prod_r      <= prod_nxt;
    tex_x_r     <= tex_x_nxt;
    out_col_r   <= out_col_nxt;
    out_floor_r <= out_floor_nxt;
    out_ceil_r  <= out_ceil_nxt;
    out_tx_r    <= out_tx_nxt;
    out_ty_r    <= out_ty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_column  = out_col_r;
  assign out_ch.floor_row   = out_floor_r;
  assign out_ch.ceiling_row = out_ceil_r;
  assign out_ch.tex_x       = out_tx_r;
  assign out_ch.tex_y       = out_ty_r;
  assign out_ch.last        = out_last_r;

endmodule

/* src/flc_div.sv */
module flc_div import flc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  flc_div_req_t req,
  output flc_div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [23:0] den_r, den_nxt;

  logic [24:0] rem_sh;
  logic [24:0] rem_sub;
  logic        ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, num_r[31]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem0;
      num_nxt  = req.num;
      quo_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        rem_nxt = ge ? rem_sub[23:0] : rem_sh[23:0];
        num_nxt = {num_r[30:0], 1'b0};
        quo_nxt = {quo_r[30:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.quo  = quo_r;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

typedef struct {
  bit [8:0]         column;
  bit               hit_side;
  bit signed [1:0]  ray_x_sign;
  bit signed [1:0]  ray_y_sign;
  bit [5:0]         cell_x;
  bit [5:0]         cell_y;
  bit [15:0]        wall_frac;
  bit [23:0]        wall_distance;
  bit signed [8:0]  draw_end;
} column_t;

typedef struct {
  bit [8:0] column;
  bit [6:0] floor_row;
  bit [7:0] ceiling_row;
  bit [5:0] tex_x;
  bit [5:0] tex_y;
  bit       last;
} pixel_pair_t;

class floor_cast_scoreboard;
  localparam int     ROWS_MAX   = flc_pkg::ROW_LIMIT;
  localparam int     HEIGHT_CAP = flc_pkg::MAX_HEIGHT;
  localparam longint ONE_Q16    = 64'd65536;

  bit [7:0]    screen_height;
  bit [21:0]   player_x;
  bit [21:0]   player_y;
  pixel_pair_t pending_pixels[$];
  int          errors;

  function new();
    screen_height = 8'd128;
    player_x      = '0;
    player_y      = '0;
    errors        = 0;
  endfunction

  function void write_reg(flc_pkg::cfg_idx_t idx, bit [21:0] data);
    case (idx)
      flc_pkg::CFG_SCREEN_HEIGHT: screen_height = data[7:0];
      flc_pkg::CFG_PLAYER_X:      player_x = data;
      flc_pkg::CFG_PLAYER_Y:      player_y = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction

  // Texture sizes are 64 and positions carry 16 fraction bits, so the
  // floored, wrapped texel index is bits 31:26 of the unscaled sum.
  function bit [5:0] texel(bit [21:0] player, longint wall, longint unsigned weight);
    longint acc;
    acc = (longint'(player) <<< 16) + longint'(weight) * (wall - longint'(player));
    return acc[31:26];
  endfunction

  function void add_column(column_t c);
    int              h;
    int              de;
    int              start_row;
    int              divisor;
    longint          cx;
    longint          cy;
    longint          fr;
    longint          wx;
    longint          wy;
    longint unsigned wd;
    longint unsigned row_dist;
    longint unsigned weight;
    pixel_pair_t     px;
    h  = (screen_height > HEIGHT_CAP) ? HEIGHT_CAP : int'(screen_height);
    de = c.draw_end;
    if (de < 0) return;
    start_row = (de < h - ROWS_MAX) ? h - ROWS_MAX : de;
    cx = longint'(c.cell_x) * ONE_Q16;
    cy = longint'(c.cell_y) * ONE_Q16;
    fr = longint'(c.wall_frac);
    wd = (c.wall_distance == 0) ? 1 : longint'(c.wall_distance);
    // floor point at the foot of the wall
    if (c.hit_side == 0 && c.ray_x_sign > 0) begin
      wx = cx;
      wy = cy + fr;
    end else if (c.hit_side == 0 && c.ray_x_sign < 0) begin
      wx = cx + ONE_Q16;
      wy = cy + fr;
    end else if (c.hit_side == 1 && c.ray_y_sign > 0) begin
      wx = cx + fr;
      wy = cy;
    end else begin
      wx = cx + fr;
      wy = cy + ONE_Q16;
    end
    for (int y = start_row; y < h; y++) begin
      divisor = 2 * y - h;
      if (divisor <= 0) begin
        row_dist = flc_pkg::DIST_MAX;
      end else begin
        row_dist = (longint'(h) << 16) / divisor;
        if (row_dist > flc_pkg::DIST_MAX) row_dist = flc_pkg::DIST_MAX;
      end
      weight = (row_dist << 16) / wd;
      if (weight > flc_pkg::WGT_MAX) weight = flc_pkg::WGT_MAX;
      px.column      = c.column;
      px.floor_row   = 7'(y);
      px.ceiling_row = 8'(h - y);
      px.tex_x       = texel(player_x, wx, weight);
      px.tex_y       = texel(player_y, wy, weight);
      px.last        = (y == h - 1);
      pending_pixels.push_back(px);
    end
  endfunction

  task report(string what);
    errors++;
    if (errors <= 60) $display("mismatch: %s", what);
  endtask

  task compare_field(string name, pixel_pair_t want, int got_val, int want_val);
    if (got_val != want_val)
      report($sformatf("column %0d row %0d: %s got %0d, want %0d",
                       want.column, want.floor_row, name, got_val, want_val));
  endtask

  task check_pixel(pixel_pair_t got);
    pixel_pair_t want;
    if (pending_pixels.size() == 0) begin
      report($sformatf("unexpected transaction: column %0d row %0d",
                       got.column, got.floor_row));
      return;
    end
    want = pending_pixels.pop_front();
    compare_field("out_column", want, got.column, want.column);
    compare_field("floor_row", want, got.floor_row, want.floor_row);
    compare_field("ceiling_row", want, got.ceiling_row, want.ceiling_row);
    compare_field("tex_x", want, got.tex_x, want.tex_x);
    compare_field("tex_y", want, got.tex_y, want.tex_y);
    compare_field("last", want, got.last, want.last);
  endtask

  task flush();
    pixel_pair_t want;
    while (pending_pixels.size() != 0) begin
      want = pending_pixels.pop_front();
      report($sformatf("missing transaction: column %0d row %0d",
                       want.column, want.floor_row));
    end
  endtask
endclass

module tb;
  import flc_pkg::*;

  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;
  bit   steady;
  int   quiet_cycles;
  int   hold_left;

  floor_cast_scoreboard sb;
  pixel_pair_t          observed;

  flc_in_if  in_ch();
  flc_out_if out_ch();
  flc_cfg_if cfg_ch();

  floor_ceiling_texture_cast_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int stall_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 80);
  endfunction

  function automatic bit [21:0] pick_player();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return 22'h3F_FFFF;
    return 22'($urandom);
  endfunction

  function automatic column_t make_column(int col, bit side, int rx, int ry, int cx, int cy,
                                          int frac, int wd, int de);
    column_t c;
    c.column        = 9'(col);
    c.hit_side      = side;
    c.ray_x_sign    = 2'(rx);
    c.ray_y_sign    = 2'(ry);
    c.cell_x        = 6'(cx);
    c.cell_y        = 6'(cy);
    c.wall_frac     = 16'(frac);
    c.wall_distance = 24'(wd);
    c.draw_end      = 9'(de);
    return c;
  endfunction

  function automatic column_t random_column(int h);
    column_t c;
    int      r;
    c.column     = 9'($urandom);
    c.hit_side   = 1'($urandom);
    c.ray_x_sign = 2'($urandom);
    c.ray_y_sign = 2'($urandom);
    c.cell_x     = 6'($urandom);
    c.cell_y     = 6'($urandom);
    c.wall_frac  = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20)      c.wall_distance = 24'($urandom_range(0, 255));
    else if (r < 70) c.wall_distance = 24'($urandom_range(24'h00_8000, 24'h7F_FFFF));
    else             c.wall_distance = 24'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80)      c.draw_end = 9'($urandom_range(0, h - 1));
    else if (r < 84) c.draw_end = -9'sd1;
    else if (r < 88) c.draw_end = 9'(h);
    else             c.draw_end = 9'($urandom);
    return c;
  endfunction

  task automatic send_column(input column_t c);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : stall_length();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.column        = c.column;
    in_ch.hit_side      = c.hit_side;
    in_ch.ray_x_sign    = c.ray_x_sign;
    in_ch.ray_y_sign    = c.ray_y_sign;
    in_ch.cell_x        = c.cell_x;
    in_ch.cell_y        = c.cell_y;
    in_ch.wall_frac     = c.wall_frac;
    in_ch.wall_distance = c.wall_distance;
    in_ch.draw_end      = c.draw_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.add_column(c);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [21:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_height(input int h);
    // upper data bits are don't-care for the height register
    write_reg(CFG_SCREEN_HEIGHT, {14'($urandom), 8'(h)});
  endtask

  // Wait out every expected transaction, then allow for a column that
  // yields nothing but may still be in flight.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stalls, none while steady
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
        out_ch.ready = 1'b0;
        hold_left    = stall_length() - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      observed.column      = out_ch.out_column;
      observed.floor_row   = out_ch.floor_row;
      observed.ceiling_row = out_ch.ceiling_row;
      observed.tex_x       = out_ch.tex_x;
      observed.tex_y       = out_ch.tex_y;
      observed.last        = out_ch.last;
      sb.check_pixel(observed);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL floor_ceiling_texture_cast_unit");
        $finish;
      end
    end
  end

  initial begin
    int heights[10];
    int eff;
    sb                  = new();
    steady              = 1'b0;
    quiet_cycles        = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.column        = '0;
    in_ch.hit_side      = 1'b0;
    in_ch.ray_x_sign    = '0;
    in_ch.ray_y_sign    = '0;
    in_ch.cell_x        = '0;
    in_ch.cell_y        = '0;
    in_ch.wall_frac     = '0;
    in_ch.wall_distance = '0;
    in_ch.draw_end      = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_SCREEN_HEIGHT;
    cfg_ch.data         = '0;
    heights = '{128, 64, 7, 33, 100, 2, 255, 90, 17, 128};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: h = 128, player at the origin
    send_column(make_column(0, 0, 1, 0, 0, 0, 0, 1, 0));            // 64 rows, clipped
    send_column(make_column(5, 0, 1, 1, 3, 4, 100, 24'h1_0000, -1));
    send_column(make_column(6, 0, 1, 1, 3, 4, 100, 24'h1_0000, 128));
    send_column(make_column(7, 1, 0, 1, 9, 9, 1, 24'h2_0000, 127)); // one row
    send_column(make_column(8, 1, 1, 1, 2, 2, 2, 24'h3_0000, -256));
    send_column(make_column(9, 1, 1, 1, 2, 2, 2, 24'h3_0000, 255));
    send_column(make_column(511, 0, -1, 1, 63, 63, 16'hFFFF, 24'hFF_FFFF, 100));
    send_column(make_column(10, 0, 0, 1, 12, 40, 16'h8000, 24'h4_8000, 110));
    send_column(make_column(11, 0, -2, -1, 30, 20, 16'h1234, 24'h2_4000, 120));
    send_column(make_column(12, 1, -1, 1, 17, 5, 16'h4321, 24'h1_8000, 115));
    send_column(make_column(13, 1, 1, -1, 40, 50, 16'hABCD, 24'h0_8000, 118));
    send_column(make_column(14, 1, 1, 0, 1, 62, 16'h0F0F, 24'h6_0000, 122));
    send_column(make_column(15, 1, -1, -2, 33, 3, 16'hF0F0, 24'h0_0100, 124));
    send_column(make_column(16, 0, 1, 0, 20, 21, 16'h5555, 0, 126)); // zero distance
    settle();

    write_height(2);
    write_reg(CFG_PLAYER_X, 22'h3F_FFFF);
    write_reg(CFG_PLAYER_Y, 22'h3F_FFFF);
    send_column(make_column(20, 0, 1, 1, 0, 0, 0, 24'h1_0000, 0)); // divisor <= 0
    send_column(make_column(21, 1, -1, -1, 63, 63, 16'hFFFF, 24'h00_0001, 1));
    send_column(make_column(22, 1, -1, 1, 5, 5, 5, 24'h1_0000, 2));
    settle();

    write_height(5);
    write_reg(CFG_PLAYER_X, 22'h15_5555);
    write_reg(CFG_PLAYER_Y, 22'h2A_AAAA);
    send_column(make_column(30, 0, -1, 1, 10, 30, 16'h7FFF, 24'h0_C000, 0));
    send_column(make_column(31, 1, 1, 1, 50, 10, 16'h8001, 24'h3_3333, 4));
    settle();

    write_height(200);  // above the cap, acts as 128
    send_column(make_column(40, 1, 0, -1, 45, 60, 16'h2222, 24'h1_4000, 0));
    send_column(make_column(41, 0, 1, 1, 45, 60, 16'h2222, 24'h1_4000, 130));
    settle();

    foreach (heights[p]) begin
      steady = (p == 3 || p == 7);
      write_height(heights[p]);
      write_reg(CFG_PLAYER_X, pick_player());
      write_reg(CFG_PLAYER_Y, pick_player());
      eff = (heights[p] > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : heights[p];
      repeat (29) send_column(random_column(eff));
      settle();
    end

    sb.flush();
    if (sb.errors == 0) begin
      $display("PASS floor_ceiling_texture_cast_unit");
    end else begin
      $display("FAIL floor_ceiling_texture_cast_unit");
    end
    $finish;
  end
endmodule

/* floor_ceiling_texture_cast_unit.f */
src/flc_pkg.sv
src/flc_in_if.sv
src/flc_out_if.sv
src/flc_cfg_if.sv
src/flc_div.sv
src/floor_ceiling_texture_cast_unit.sv
sim/tb.sv
